[rtl/wra_pkg.sv]
// ---------------------------------------------------------------------------
// wra_pkg
// Shared types and constants of the weight running average unit.
// ---------------------------------------------------------------------------
`default_nettype none

package wra_pkg;

  localparam int IDX_W  = 12;
  localparam int AVG_W  = 32;
  localparam int CNT_W  = 32;
  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIFF_W = AVG_W + 1;
  localparam int DIVS_W = CNT_W + 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                     opcode;
    logic [IDX_W-1:0]        index;
    logic signed [AVG_W-1:0] weight;
    logic                    end_of_pass;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index_out;
    logic signed [AVG_W-1:0] average;
    logic [CNT_W-1:0]        passes_done;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/wra_store.sv]
// ---------------------------------------------------------------------------
// wra_store
// Dual-port style mean store with one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module wra_store (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [wra_pkg::ADDR_W-1:0]      wr_addr,
  input  wire logic signed [wra_pkg::AVG_W-1:0] wr_data,
  input  wire logic                            rd_en,
  input  wire logic [wra_pkg::ADDR_W-1:0]      rd_addr,
  output logic signed [wra_pkg::AVG_W-1:0]     rd_data_r
);

  logic signed [wra_pkg::AVG_W-1:0] mem [wra_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/wra_divider.sv]
// ---------------------------------------------------------------------------
// wra_divider
// Bit-serial restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module wra_divider (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [wra_pkg::DIFF_W-1:0] dividend,
  input  wire logic [wra_pkg::DIVS_W-1:0]       divisor,
  output logic                                  done_r,
  output logic signed [wra_pkg::DIFF_W-1:0]     quotient
);

  localparam int STEP_W = $clog2(wra_pkg::DIFF_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(wra_pkg::DIFF_W - 1);

  logic                          busy_r;
  logic [STEP_W-1:0]             step_r;
  logic                          sign_r;
  logic [wra_pkg::DIVS_W-1:0]    rem_r;
  logic [wra_pkg::DIVS_W-1:0]    divisor_r;
  logic [wra_pkg::DIFF_W-1:0]    dq_r;
  logic [wra_pkg::DIFF_W-1:0]    magnitude;
  logic [wra_pkg::DIVS_W:0]      shifted;
  logic [wra_pkg::DIVS_W+1:0]    trial;
  logic                          qbit;

  always_comb begin
    magnitude = dividend[wra_pkg::DIFF_W-1] ? wra_pkg::DIFF_W'(-dividend)
                                             : wra_pkg::DIFF_W'(dividend);
    shifted   = {rem_r, dq_r[wra_pkg::DIFF_W-1]};
    trial     = {1'b0, shifted} - {2'b00, divisor_r};
    qbit      = ~trial[wra_pkg::DIVS_W+1];
    quotient  = sign_r ? -$signed(dq_r) : $signed(dq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sign_r    <= dividend[wra_pkg::DIFF_W-1];
      dq_r      <= magnitude;
      rem_r     <= '0;
      divisor_r <= divisor;
      step_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= qbit ? trial[wra_pkg::DIVS_W-1:0] : shifted[wra_pkg::DIVS_W-1:0];
      dq_r   <= {dq_r[wra_pkg::DIFF_W-2:0], qbit};
      step_r <= step_r + STEP_W'(1);
    end
  end

endmodule

`default_nettype wire

[rtl/weight_running_average_unit.sv]
// ---------------------------------------------------------------------------
// weight_running_average_unit
// Elementwise cumulative moving average of weights over a store of means.
// ---------------------------------------------------------------------------
// A read item, or an update while the pass count is zero, goes from load
// to done; an averaging update waits between them in the divide state for
// the bit-serial divider. The result is registered on leaving done, once the
// output is free, and only then does idle take the next item.
// Reset clears the pass count and the control state; the store keeps no reset.
`default_nettype none

module weight_running_average_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire wra_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wra_pkg::out_item_t      out_data
);

  wra_pkg::state_t                   state_r, state_nxt;
  wra_pkg::op_t                      op_r;
  logic [wra_pkg::IDX_W-1:0]         idx_r;
  logic signed [wra_pkg::AVG_W-1:0]  w_r;
  logic                              eop_r;
  logic signed [wra_pkg::AVG_W-1:0]  mean_r, mean_nxt;
  logic [wra_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              out_valid_r, out_valid_nxt;
  wra_pkg::out_item_t                out_r;

  logic                              in_fire;
  logic                              rd_en;
  logic                              wr_en;
  logic                              div_start;
  logic                              div_done;
  logic                              load_out;
  logic signed [wra_pkg::AVG_W-1:0]  rd_data;
  logic signed [wra_pkg::DIFF_W-1:0] diff;
  logic signed [wra_pkg::DIFF_W-1:0] quotient;
  logic [wra_pkg::DIVS_W-1:0]        divisor;

  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign diff      = {w_r[wra_pkg::AVG_W-1], w_r} - {rd_data[wra_pkg::AVG_W-1], rd_data};
  assign divisor   = {1'b0, count_r} + wra_pkg::DIVS_W'(1);

  wra_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (idx_r[wra_pkg::ADDR_W-1:0]),
    .wr_data   (mean_r),
    .rd_en     (rd_en),
    .rd_addr   (in_data.index[wra_pkg::ADDR_W-1:0]),
    .rd_data_r (rd_data)
  );

  wra_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  (divisor),
    .done_r   (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    mean_nxt  = mean_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      wra_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rd_en     = 1'b1;
          state_nxt = wra_pkg::ST_LOAD;
        end
      end
      wra_pkg::ST_LOAD: begin
        priority if (op_r == wra_pkg::OP_READ) begin
          mean_nxt  = rd_data;
          state_nxt = wra_pkg::ST_DONE;
        end else if (count_r == '0) begin
          mean_nxt  = w_r;
          state_nxt = wra_pkg::ST_DONE;
        end else begin
          mean_nxt  = rd_data;
          div_start = 1'b1;
          state_nxt = wra_pkg::ST_DIV;
        end
      end
      wra_pkg::ST_DIV: begin
        if (div_done) begin
          mean_nxt  = mean_r + quotient[wra_pkg::AVG_W-1:0];
          state_nxt = wra_pkg::ST_DONE;
        end
      end
      wra_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          wr_en     = (op_r == wra_pkg::OP_UPDATE);
          state_nxt = wra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wra_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (load_out && op_r == wra_pkg::OP_UPDATE && eop_r && count_r != wra_pkg::COUNT_MAX) begin
      count_nxt = count_r + wra_pkg::CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wra_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mean_r <= mean_nxt;
    if (in_fire) begin
      op_r  <= in_data.opcode;
      idx_r <= in_data.index;
      w_r   <= in_data.weight;
      eop_r <= in_data.end_of_pass;
    end
    if (load_out) begin
      out_r.index_out   <= idx_r;
      out_r.average     <= mean_r;
      out_r.passes_done <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[dv/weight_running_average_unit_test.sv]
// ---------------------------------------------------------------------------
// weight_running_average_unit_test
// Self-checking testbench for the weight running average unit. It keeps its
// own copy of the mean store and the pass count, predicts each result as an
// item is accepted, and compares every result against the oldest prediction.
// Directed extremes run first. Random traffic with random gaps on both sides
// follows, with one long receiver stall and one full drain.
// ---------------------------------------------------------------------------
`default_nettype none

module weight_running_average_unit_test;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 4;
  localparam int MAX_GAP       = 13;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int FILL_ITEMS    = 150;
  localparam int CHUNK_ITEMS   = 50;
  localparam int CHUNKS        = 18;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  wra_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  wra_pkg::out_item_t out_data;

  logic signed [wra_pkg::AVG_W-1:0] mean_mem [wra_pkg::DEPTH];
  bit                               slot_written [wra_pkg::DEPTH];
  logic [wra_pkg::CNT_W-1:0]        passes = '0;
  wra_pkg::out_item_t               pending_averages [$];
  int unsigned                      filled_slots [$];

  bit tx_gaps_on   = 1'b1;
  bit rx_gaps_on   = 1'b1;
  bit hold_request = 1'b0;
  bit result_taken = 1'b0;
  int rx_delay     = 0;
  int stall_cycles = 0;
  int mismatches   = 0;
  int n_updates    = 0;
  int n_reads      = 0;
  int n_checked    = 0;

  weight_running_average_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic wra_pkg::out_item_t track_running_mean(wra_pkg::in_item_t item);
    wra_pkg::out_item_t res;
    int unsigned        slot;
    longint             prev_mean;
    longint             step;
    slot = item.index % wra_pkg::DEPTH;
    if (item.opcode == wra_pkg::OP_UPDATE) begin
      if (passes == '0) begin
        mean_mem[slot] = item.weight;
      end else begin
        prev_mean      = longint'(mean_mem[slot]);
        step           = (longint'($signed(item.weight)) - prev_mean) /
                         (longint'(passes) + 64'sd1);
        mean_mem[slot] = wra_pkg::AVG_W'(prev_mean + step);
      end
      if (!slot_written[slot]) begin
        slot_written[slot] = 1'b1;
        filled_slots.insert(filled_slots.size(), slot);
      end
      if (item.end_of_pass && passes != wra_pkg::COUNT_MAX) begin
        passes = passes + wra_pkg::CNT_W'(1);
      end
    end
    res.index_out   = item.index;
    res.average     = mean_mem[slot];
    res.passes_done = passes;
    return res;
  endfunction

  function automatic logic [wra_pkg::AVG_W-1:0] pick_weight(int unsigned slot);
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return slot_written[slot]
                ? (mean_mem[slot] ^ wra_pkg::AVG_W'($urandom_range(0, 255)))
                : wra_pkg::AVG_W'($urandom);
      default: return wra_pkg::AVG_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input wra_pkg::op_t op, input int unsigned idx,
                           input logic [wra_pkg::AVG_W-1:0] w, input bit eop);
    wra_pkg::in_item_t item;
    int                gap;
    item.opcode      = op;
    item.index       = wra_pkg::IDX_W'(idx);
    item.weight      = w;
    item.end_of_pass = eop;
    gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_averages.insert(pending_averages.size(), track_running_mean(item));
    if (op == wra_pkg::OP_UPDATE) begin
      n_updates++;
    end else begin
      n_reads++;
    end
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned slot;
    slot = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
    if ($urandom_range(0, 9) < 7) begin
      send_item(wra_pkg::OP_UPDATE, slot, pick_weight(slot), $urandom_range(0, 29) == 0);
    end else begin
      send_item(wra_pkg::OP_READ, slot, wra_pkg::AVG_W'($urandom),
                1'($urandom_range(0, 1)));
    end
  endtask

  // While the pass count is zero, updates store the weight as it is.
  task automatic test_first_pass_extremes();
    send_item(wra_pkg::OP_UPDATE, 0, 32'h7FFF_FFFF, 1'b0);
    send_item(wra_pkg::OP_UPDATE, 4095, 32'h8000_0000, 1'b0);
    send_item(wra_pkg::OP_UPDATE, 12'hAAA, 32'h0000_0000, 1'b0);
    send_item(wra_pkg::OP_UPDATE, 12'h555, 32'hFFFF_FFFF, 1'b0);
    send_item(wra_pkg::OP_UPDATE, 1, 32'h0001_0000, 1'b0);
    send_item(wra_pkg::OP_READ, 0, 32'hFFFF_FFFF, 1'b1);
    send_item(wra_pkg::OP_READ, 4095, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_fill_store();
    int unsigned slot;
    repeat (FILL_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        slot = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
        send_item(wra_pkg::OP_READ, slot, wra_pkg::AVG_W'($urandom),
                  1'($urandom_range(0, 1)));
      end else begin
        slot = $urandom_range(0, wra_pkg::DEPTH - 1);
        send_item(wra_pkg::OP_UPDATE, slot, pick_weight(slot), 1'b0);
      end
    end
    slot = $urandom_range(0, wra_pkg::DEPTH - 1);
    send_item(wra_pkg::OP_UPDATE, slot, wra_pkg::AVG_W'($urandom), 1'b1);
  endtask

  // The pass count is one here, so each update halves the distance to the
  // weight, and odd negative differences must truncate toward zero.
  task automatic test_average_extremes();
    send_item(wra_pkg::OP_UPDATE, 0, 32'h8000_0000, 1'b0);
    send_item(wra_pkg::OP_UPDATE, 4095, 32'h7FFF_FFFF, 1'b0);
    send_item(wra_pkg::OP_UPDATE, 1, 32'hFFFF_FFFF, 1'b0);
    send_item(wra_pkg::OP_UPDATE, 12'h555, 32'h0000_0000, 1'b0);
    send_item(wra_pkg::OP_UPDATE, 12'hAAA, 32'hFFFF_FFFD, 1'b1);
    send_item(wra_pkg::OP_READ, 0, 32'h0000_0000, 1'b1);
    send_item(wra_pkg::OP_READ, 12'hAAA, 32'h0000_0000, 1'b0);
    send_item(wra_pkg::OP_READ, 1, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_random_traffic();
    repeat (CHUNKS) begin
      tx_gaps_on = $urandom_range(0, 2) != 0;
      rx_gaps_on = $urandom_range(0, 2) != 0;
      repeat (CHUNK_ITEMS) send_random_item();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_receiver_hold();
    tx_gaps_on   = 1'b0;
    hold_request = 1'b1;
    repeat (12) send_random_item();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (20) send_random_item();
    idle_input();
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (20) send_random_item();
  endtask

  always @(negedge clk) begin
    if (result_taken) begin
      result_taken = 1'b0;
      rx_delay     = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    end
    if (hold_request) begin
      hold_request = 1'b0;
      rx_delay     = HOLD_CYCLES;
    end
    if (rx_delay > 0) begin
      out_ready = 1'b0;
      rx_delay--;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    wra_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      result_taken = 1'b1;
      if (pending_averages.size() == 0) begin
        $display("%0t: result with no item outstanding, got %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending_averages.pop_front();
        n_checked++;
        if (out_data.index_out !== want.index_out) begin
          $display("%0t: index_out expected %0d, got %0d",
                   $time, want.index_out, out_data.index_out);
          mismatches++;
        end
        if (out_data.average !== want.average) begin
          $display("%0t: average at index %0d expected %0d, got %0d",
                   $time, want.index_out, want.average, out_data.average);
          mismatches++;
        end
        if (out_data.passes_done !== want.passes_done) begin
          $display("%0t: passes_done expected %0d, got %0d",
                   $time, want.passes_done, out_data.passes_done);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_averages.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_first_pass_extremes();
    test_fill_store();
    test_average_extremes();
    test_random_traffic();
    test_receiver_hold();
    test_drain_pause();
    idle_input();
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d updates and %0d reads over %0d store entries; %0d results checked.",
             n_updates, n_reads, filled_slots.size(), n_checked);
    $display("Final pass count %0d, %0d mismatches found.", passes, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
